### rtl/qfc_pkg.sv
// Package for the QR function-module classifier: class codes, register
// indexes, widths and the shared pattern functions. No dependencies.
`timescale 1ns / 1ps

package qfc_pkg;

	localparam int ALIGN_SLOTS_MAX = 7;
	localparam int ALIGN_SLOTS_DEF = 7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int VER_W      = 6;
	localparam int COORD_W    = 8;
	localparam int SIZE_W     = 9;

	localparam logic [CFG_IDX_W-1:0] REG_VERSION    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_BASE = 3'd1;

	localparam logic [VER_W-1:0] VERSION_RST = 6'd1;
	localparam logic [VER_W-1:0] VERSION_MIN_INFO = 6'd7;

	typedef enum logic [2:0] {
		CLS_DATA      = 3'd0,
		CLS_DARK      = 3'd1,
		CLS_FORMAT    = 3'd2,
		CLS_VERSION   = 3'd3,
		CLS_FINDER    = 3'd4,
		CLS_SEPARATOR = 3'd5,
		CLS_TIMING    = 3'd6,
		CLS_ALIGN     = 3'd7
	} cls_t;

	typedef struct packed {
		logic busy;
	} qfc_cfg_status_t;

	function automatic logic [SIZE_W-1:0] sym_size(input logic [VER_W-1:0] v);
		sym_size = {1'b0, v, 2'b00} + 9'd17;
	endfunction

	// |a - b| <= 2
	function automatic logic near2(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
		logic [COORD_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		near2 = (d <= 8'd2);
	endfunction

	// class of a module before alignment blocks are painted; later rules override
	function automatic cls_t base_class(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
			input logic [VER_W-1:0] v);
		logic [SIZE_W-1:0] rr;
		logic [SIZE_W-1:0] cc;
		logic [SIZE_W-1:0] sz;
		logic [SIZE_W-1:0] dark_r;
		cls_t k;
		rr = {1'b0, r};
		cc = {1'b0, c};
		sz = sym_size(v);
		dark_r = {1'b0, v, 2'b00} + 9'd9;
		k = CLS_DATA;
		if (rr == dark_r && cc == 9'd8) k = CLS_DARK;
		if (rr == 9'd8 && (cc <= 9'd5 || cc == 9'd7 || cc == 9'd8)) k = CLS_FORMAT;
		if (cc == 9'd8 && (rr <= 9'd5 || rr == 9'd7 || rr == 9'd8)) k = CLS_FORMAT;
		if (cc == 9'd8 && rr >= sz - 9'd7 && rr < sz) k = CLS_FORMAT;
		if (rr == 9'd8 && cc >= sz - 9'd8 && cc < sz) k = CLS_FORMAT;
		if (v >= VERSION_MIN_INFO) begin
			if (rr >= sz - 9'd11 && rr <= sz - 9'd9 && cc <= 9'd5) k = CLS_VERSION;
			if (cc >= sz - 9'd11 && cc <= sz - 9'd9 && rr <= 9'd5) k = CLS_VERSION;
		end
		if ((rr < 9'd7 && cc < 9'd7) || (rr >= sz - 9'd7 && cc < 9'd7) ||
				(rr < 9'd7 && cc >= sz - 9'd7))
			k = CLS_FINDER;
		if ((rr == 9'd7 && cc < 9'd8) || (cc == 9'd7 && rr < 9'd8) ||
				(rr == 9'd7 && cc >= sz - 9'd8) || (cc == 9'd7 && rr >= sz - 9'd8) ||
				(cc == sz - 9'd8 && rr < 9'd8) || (rr == sz - 9'd8 && cc < 9'd8))
			k = CLS_SEPARATOR;
		if ((cc == 9'd6 && rr >= 9'd8 && rr < sz - 9'd8) ||
				(rr == 9'd6 && cc >= 9'd8 && cc < sz - 9'd8))
			k = CLS_TIMING;
		base_class = k;
	endfunction

endpackage

### rtl/qfc_cfg.sv
// Configuration registers and the alignment-center acceptance sweep.
// Depends on qfc_pkg.
`timescale 1ns / 1ps

module qfc_cfg import qfc_pkg::*; #(
	parameter int ALIGN_SLOTS = ALIGN_SLOTS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]                    cfg_index,
	input  logic [CFG_DATA_W-1:0]                   cfg_data,
	output logic [VER_W-1:0]                        version,
	output logic [ALIGN_SLOTS-1:0][COORD_W-1:0]     align_pos,
	output logic [ALIGN_SLOTS-1:0][ALIGN_SLOTS-1:0] acc_mask,
	output qfc_cfg_status_t                         status
);

	localparam int IW = (ALIGN_SLOTS > 1) ? $clog2(ALIGN_SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(ALIGN_SLOTS - 1);

	logic [VER_W-1:0]                        version_q;
	logic [ALIGN_SLOTS-1:0][COORD_W-1:0]     pos_q;
	logic [ALIGN_SLOTS-1:0][ALIGN_SLOTS-1:0] acc_q;
	logic                                    busy_q;
	logic [IW-1:0]                           i_q;
	logic [IW-1:0]                           j_q;

	logic [COORD_W-1:0]     cr;
	logic [COORD_W-1:0]     cc;
	logic [SIZE_W-1:0]      sz;
	logic [ALIGN_SLOTS-1:0] rn;
	logic [ALIGN_SLOTS-1:0] cn;
	logic                   covered;
	logic                   in_range;
	cls_t                   ck;
	logic                   take;

	// pair (i, j) is checked against every center accepted earlier in the scan
	always_comb begin
		cr = pos_q[i_q];
		cc = pos_q[j_q];
		sz = sym_size(version_q);
		covered = 1'b0;
		for (int a = 0; a < ALIGN_SLOTS; a++) begin
			rn[a] = near2(pos_q[a], cr);
			cn[a] = near2(pos_q[a], cc);
		end
		for (int a = 0; a < ALIGN_SLOTS; a++)
			for (int b = 0; b < ALIGN_SLOTS; b++)
				covered = covered | (acc_q[a][b] & rn[a] & cn[b]);
		in_range = (cr != '0) && (cc != '0) && ({1'b0, cr} < sz) && ({1'b0, cc} < sz);
		ck = base_class(cr, cc, version_q);
		take = in_range && !covered && (ck == CLS_DATA || ck == CLS_TIMING);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RST;
			pos_q     <= '0;
			acc_q     <= '0;
			busy_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_VERSION)
				version_q <= cfg_data[VER_W-1:0];
			for (int k = 0; k < ALIGN_SLOTS; k++)
				if (cfg_index == REG_ALIGN_BASE + CFG_IDX_W'(k))
					pos_q[k] <= cfg_data;
			// any write restarts the sweep from scratch
			acc_q  <= '0;
			busy_q <= 1'b1;
			i_q    <= '0;
			j_q    <= '0;
		end else if (busy_q) begin
			if (take)
				acc_q[i_q][j_q] <= 1'b1;
			if (j_q == LAST) begin
				j_q <= '0;
				if (i_q == LAST)
					busy_q <= 1'b0;
				else
					i_q <= i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	assign version     = version_q;
	assign align_pos   = pos_q;
	assign acc_mask    = acc_q;
	assign status.busy = busy_q;

endmodule

### rtl/qfc_classify.sv
// Classification pipeline: input register, pattern logic, result register.
// Depends on qfc_pkg.
`timescale 1ns / 1ps

module qfc_classify import qfc_pkg::*; #(
	parameter int ALIGN_SLOTS = ALIGN_SLOTS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [COORD_W-1:0]                      in_row,
	input  logic [COORD_W-1:0]                      in_col,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [2:0]                              out_class,
	output logic                                    out_outside,
	input  logic [VER_W-1:0]                        version,
	input  logic [ALIGN_SLOTS-1:0][COORD_W-1:0]     align_pos,
	input  logic [ALIGN_SLOTS-1:0][ALIGN_SLOTS-1:0] acc_mask
);

	logic               v_s1;
	logic [COORD_W-1:0] row_s1;
	logic [COORD_W-1:0] col_s1;
	logic               v_s2;
	cls_t               cls_s2;
	logic               outside_s2;

	logic                   adv;
	logic [SIZE_W-1:0]      sz;
	logic                   outside;
	logic [ALIGN_SLOTS-1:0] rn;
	logic [ALIGN_SLOTS-1:0] cn;
	logic                   hit;
	cls_t                   cls;

	always_comb begin
		sz = sym_size(version);
		outside = ({1'b0, row_s1} >= sz) || ({1'b0, col_s1} >= sz);
		hit = 1'b0;
		for (int a = 0; a < ALIGN_SLOTS; a++) begin
			rn[a] = near2(row_s1, align_pos[a]);
			cn[a] = near2(col_s1, align_pos[a]);
		end
		for (int a = 0; a < ALIGN_SLOTS; a++)
			for (int b = 0; b < ALIGN_SLOTS; b++)
				hit = hit | (acc_mask[a][b] & rn[a] & cn[b]);
		if (outside)
			cls = CLS_DATA;
		else if (hit)
			cls = CLS_ALIGN;
		else
			cls = base_class(row_s1, col_s1, version);
	end

	assign adv      = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (adv)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			row_s1 <= in_row;
			col_s1 <= in_col;
		end
		if (adv && v_s1) begin
			cls_s2     <= cls;
			outside_s2 <= outside;
		end
	end

	assign out_valid   = v_s2;
	assign out_class   = cls_s2;
	assign out_outside = outside_s2;

endmodule

### rtl/qr_function_module_classifier_top.sv
// Top level of the QR function-module classifier.
// Depends on qfc_pkg, qfc_cfg and qfc_classify.
//
//   channel   dir  handshake            payload
//   s_axis    in   s_tvalid/s_tready    s_tdata: row[7:0], col[15:8]
//   m_axis    out  m_tvalid/m_tready    m_tdata: module_class[2:0], outside[3], zero[7:4]
//   cfg       in   cfg_wr_en            cfg_index (0 version, 1..7 align_pos), cfg_data
//
// One transaction per cycle unless a sweep or a result stall holds it; an accepted
// item passes the input register, then the result register. Under a result stall,
// both stages hold, and the input stage still moves up into an empty result stage.
// Reset gives version 1 with no alignment centers; no sweep is needed after it.
// Every configuration write starts a sweep over the ALIGN_SLOTS*ALIGN_SLOTS center pairs
// (one center pair per cycle) that settles which centers are painted;
// s_tready is low while it runs.
`timescale 1ns / 1ps

module qr_function_module_classifier_top import qfc_pkg::*; #(
	parameter int ALIGN_SLOTS = ALIGN_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // row[7:0], col[15:8]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // module_class[2:0], outside[3], zero[7:4]
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [VER_W-1:0]                        version;
	logic [ALIGN_SLOTS-1:0][COORD_W-1:0]     align_pos;
	logic [ALIGN_SLOTS-1:0][ALIGN_SLOTS-1:0] acc_mask;
	qfc_cfg_status_t                         cfg_status;
	logic                                    cls_in_ready;
	logic [2:0]                              out_class;
	logic                                    out_outside;

	qfc_cfg #(
		.ALIGN_SLOTS(ALIGN_SLOTS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.version   (version),
		.align_pos (align_pos),
		.acc_mask  (acc_mask),
		.status    (cfg_status)
	);

	qfc_classify #(
		.ALIGN_SLOTS(ALIGN_SLOTS)
	) u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid && !cfg_status.busy),
		.in_ready    (cls_in_ready),
		.in_row      (s_tdata[7:0]),
		.in_col      (s_tdata[15:8]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_class   (out_class),
		.out_outside (out_outside),
		.version     (version),
		.align_pos   (align_pos),
		.acc_mask    (acc_mask)
	);

	assign s_tready = cls_in_ready && !cfg_status.busy;
	assign m_tdata  = {4'b0000, out_outside, out_class};

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_status.busy |-> !s_tready)
		else $error("input accepted during center sweep");

	a_write_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> cfg_status.busy)
		else $error("configuration write did not start sweep");

	a_outside_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_outside) |-> (out_class == CLS_DATA))
		else $error("outside coordinate reported a non-data class");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:4] == 4'b0000))
		else $error("result padding not zero");

endmodule

### verif/qfc_module_map_check.sv
// Checker for the QR function-module classifier: tracks the register writes,
// predicts the class of every accepted coordinate and compares the results.
// Depends on qfc_pkg for widths, register indexes and the class codes.
`timescale 1ns / 1ps

module qfc_module_map_check import qfc_pkg::*; #(
	parameter int SLOTS = ALIGN_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [15:0]           s_tdata,   // row[7:0], col[15:8]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [7:0]            m_tdata,   // module_class[2:0], outside[3], zero[7:4]
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    awaited,
	output int                    fail_count
);

	typedef struct packed {
		logic outside;
		cls_t kind;
	} cell_verdict_t;

	logic [VER_W-1:0]   ver_q;
	logic [COORD_W-1:0] ctr_q [ALIGN_SLOTS_MAX];
	cell_verdict_t      awaited_cells [$];

	function automatic bit close2(input int a, input int b);
		return (a - b <= 2) && (b - a <= 2);
	endfunction

	// fixed patterns only; each later rule overrides the earlier ones
	function automatic cls_t pattern_class(input int r, input int c, input int v, input int sz);
		cls_t k;
		k = CLS_DATA;
		if (r == 4 * v + 9 && c == 8) k = CLS_DARK;
		if (r == 8 && (c <= 5 || c == 7 || c == 8)) k = CLS_FORMAT;
		if (c == 8 && (r <= 5 || r == 7 || r == 8)) k = CLS_FORMAT;
		if (c == 8 && r >= sz - 7 && r < sz) k = CLS_FORMAT;
		if (r == 8 && c >= sz - 8 && c < sz) k = CLS_FORMAT;
		if (v >= 7) begin
			if (r >= sz - 11 && r <= sz - 9 && c <= 5) k = CLS_VERSION;
			if (c >= sz - 11 && c <= sz - 9 && r <= 5) k = CLS_VERSION;
		end
		if ((r < 7 && c < 7) || (r >= sz - 7 && c < 7) || (r < 7 && c >= sz - 7))
			k = CLS_FINDER;
		if ((r == 7 && c < 8) || (c == 7 && r < 8) || (r == 7 && c >= sz - 8) ||
				(c == 7 && r >= sz - 8) || (c == sz - 8 && r < 8) || (r == sz - 8 && c < 8))
			k = CLS_SEPARATOR;
		if ((c == 6 && r >= 8 && r < sz - 8) || (r == 6 && c >= 8 && c < sz - 8))
			k = CLS_TIMING;
		return k;
	endfunction

	function automatic cell_verdict_t predict_cell(input logic [7:0] row_in,
			input logic [7:0] col_in);
		int r, c, v, sz, cr, cc;
		int held_r [$];
		int held_c [$];
		bit covered;
		cls_t k, ck;
		cell_verdict_t res;
		r = row_in;
		c = col_in;
		v = ver_q;
		sz = 4 * v + 17;
		res.outside = 1'b0;
		res.kind = CLS_DATA;
		if (r >= sz || c >= sz) begin
			res.outside = 1'b1;
			return res;
		end
		k = pattern_class(r, c, v, sz);
		// centers row-major over the pairs; blocks already placed count as taken
		for (int i = 0; i < SLOTS; i++) begin
			for (int j = 0; j < SLOTS; j++) begin
				cr = ctr_q[i];
				cc = ctr_q[j];
				if (cr == 0 || cc == 0 || cr >= sz || cc >= sz) continue;
				covered = 1'b0;
				foreach (held_r[p])
					if (close2(cr, held_r[p]) && close2(cc, held_c[p])) covered = 1'b1;
				ck = covered ? CLS_ALIGN : pattern_class(cr, cc, v, sz);
				if (ck != CLS_DATA && ck != CLS_TIMING) continue;
				held_r.push_back(cr);
				held_c.push_back(cc);
				if (close2(r, cr) && close2(c, cc)) k = CLS_ALIGN;
			end
		end
		res.kind = k;
		return res;
	endfunction

	task automatic note_miss(input string field, input int want, input int got);
		fail_count++;
		if (fail_count <= 100) $error("%s: expected %0d, got %0d", field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cell_verdict_t want;
		if (!arst_n) begin
			ver_q = VERSION_RST;
			foreach (ctr_q[i]) ctr_q[i] = '0;
			awaited_cells.delete();
			fail_count = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_VERSION)
					ver_q = cfg_data[VER_W-1:0];
				else
					ctr_q[cfg_index - REG_ALIGN_BASE] = cfg_data;
			end
			if (s_tvalid && s_tready)
				awaited_cells.push_back(predict_cell(s_tdata[7:0], s_tdata[15:8]));
			if (m_tvalid && m_tready) begin
				if (awaited_cells.size() == 0) begin
					fail_count++;
					if (fail_count <= 100) $error("result with no transaction pending: %h", m_tdata);
				end else begin
					want = awaited_cells.pop_front();
					if (m_tdata[2:0] != want.kind) note_miss("module_class", want.kind, m_tdata[2:0]);
					if (m_tdata[3] != want.outside) note_miss("outside", want.outside, m_tdata[3]);
					if (m_tdata[7:4] != 4'd0) note_miss("zero pad", 0, m_tdata[7:4]);
				end
			end
		end
		awaited <= awaited_cells.size();
	end

endmodule

### verif/tb.sv
// Testbench top for the QR function-module classifier: clock, reset, register
// writes, coordinate stimulus and result back-pressure; verdict from the checker.
// Depends on qfc_pkg, qr_function_module_classifier_top and qfc_module_map_check.
`timescale 1ns / 1ps

module tb import qfc_pkg::*;;

	localparam int LIMIT       = 2000;
	localparam int HOLD_CYCLES = 40;
	localparam int PHASES      = 13;
	localparam int PHASE_ITEMS = 133;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;   // row[7:0], col[15:8]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;   // module_class[2:0], outside[3], zero[7:4]
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int awaited;
	int fail_count;
	int quiet;
	bit steady;
	bit hold_off;

	logic [VER_W-1:0]   cur_ver;
	logic [COORD_W-1:0] cur_ctr [ALIGN_SLOTS_MAX];

	qr_function_module_classifier_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	qfc_module_map_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.awaited    (awaited),
		.fail_count (fail_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic [7:0] clip8(input int x);
		return (x < 0) ? 8'd0 : (x > 255) ? 8'd255 : x[7:0];
	endfunction

	// mostly inside the symbol, a share near pattern edges and centers, some anywhere
	function automatic logic [7:0] pick_coord();
		int sz, lim, roll, base, off;
		sz = 4 * int'(cur_ver) + 17;
		lim = (sz > 256) ? 255 : sz - 1;
		roll = $urandom_range(99);
		off = $urandom_range(6);
		if (roll < 65) return 8'($urandom_range(lim));
		if (roll < 88) begin
			case ($urandom_range(5))
				0:       base = cur_ctr[$urandom_range(ALIGN_SLOTS_MAX - 1)];
				1:       base = 6;
				2:       base = 8;
				3:       base = sz - 8;
				4:       base = 4 * int'(cur_ver) + 9;
				default: base = sz - 11;
			endcase
			return clip8(base + off - 3);
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic send_cell(input logic [7:0] r, input logic [7:0] c);
		int gap;
		gap = steady ? 0 : $urandom_range(9);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {c, r};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (awaited != 0) @(negedge clk);
	endtask

	// each write kicks off a center sweep; ready comes back when it is done
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [7:0] ver_data);
		cur_ver = ver_data[VER_W-1:0];
		write_reg(REG_VERSION, ver_data);
		for (int i = 0; i < ALIGN_SLOTS_MAX; i++)
			write_reg(REG_ALIGN_BASE + CFG_IDX_W'(i), cur_ctr[i]);
	endtask

	initial begin : drain
		int pause;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready = 1'b0;
				hold_off = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			pause = steady ? 0 : $urandom_range(9);
			if (pause != 0) begin
				m_tready = 1'b0;
				repeat (pause) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stim
		int sz, lim, roll, off;
		logic [7:0] ver_data;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		hold_off = 1'b0;
		cur_ver = VERSION_RST;
		foreach (cur_ctr[i]) cur_ctr[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setting: version 1, size 21, no alignment
		send_cell(8'd0, 8'd0);
		send_cell(8'd255, 8'd255);
		send_cell(8'd8, 8'd8);
		send_cell(8'd13, 8'd8);
		send_cell(8'd6, 8'd12);
		send_cell(8'd7, 8'd7);
		send_cell(8'd13, 8'd7);
		send_cell(8'd20, 8'd20);
		send_cell(8'd21, 8'd5);
		send_cell(8'd5, 8'd21);
		send_cell(8'd10, 8'd10);
		send_cell(8'd8, 8'd20);
		send_cell(8'd20, 8'd8);
		settle();

		// version 7 (upper data bits set), centers on finder, timing and a near-duplicate
		cur_ctr = '{8'd6, 8'd22, 8'd38, 8'd23, 8'd0, 8'd0, 8'd0};
		apply_config(8'h47);
		send_cell(8'd34, 8'd0);
		send_cell(8'd0, 8'd36);
		send_cell(8'd22, 8'd22);
		send_cell(8'd20, 8'd24);
		send_cell(8'd19, 8'd22);
		send_cell(8'd6, 8'd20);
		send_cell(8'd4, 8'd22);
		send_cell(8'd8, 8'd8);
		send_cell(8'd37, 8'd8);
		send_cell(8'd44, 8'd44);
		send_cell(8'd45, 8'd0);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				cur_ctr = '{8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142, 8'd170};
				ver_data = 8'd40;
			end else if (ph == 2) begin
				cur_ctr = '{8'd255, 8'd1, 8'd128, 8'd254, 8'd2, 8'd176, 8'd177};
				ver_data = 8'h3F;
			end else begin
				if (ph == 1)
					ver_data = 8'hC0;
				else if ($urandom_range(7) == 0)
					ver_data = 8'($urandom_range(255));
				else
					ver_data = {2'($urandom_range(3)), 6'($urandom_range(40, 1))};
				sz = 4 * int'(ver_data[VER_W-1:0]) + 17;
				lim = (sz > 256) ? 255 : sz - 1;
				for (int i = 0; i < ALIGN_SLOTS_MAX; i++) begin
					roll = $urandom_range(99);
					off = $urandom_range(6);
					if (roll < 20)
						cur_ctr[i] = 8'd0;
					else if (roll < 25)
						cur_ctr[i] = 8'd6;
					else if (roll < 30)
						cur_ctr[i] = clip8(sz - 7);
					else if (roll < 65 || i == 0)
						cur_ctr[i] = 8'($urandom_range(lim));
					else if (roll < 85)
						cur_ctr[i] = clip8(int'(cur_ctr[i-1]) + off - 3);
					else
						cur_ctr[i] = 8'($urandom_range(255));
				end
			end
			apply_config(ver_data);
			steady = (ph == 0) || ($urandom_range(3) == 0);
			// back-to-back items against a long receiver hold fill the pipeline
			if (ph == 0) hold_off = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_cell(pick_coord(), pick_coord());
			settle();
		end

		steady = 1'b0;
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
